@@ rtl/bfpa_pkg.sv @@
package bfpa_pkg;

  localparam int unsigned POOL_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned MAX_SEGMENTS = 256;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned ADDR_W = 12;
  localparam int unsigned SIZE_W = 13;
  localparam int unsigned STAT_W = 3;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_FREE  = 2'd1,
    MODE_INIT  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    STS_OK        = 3'd0,
    STS_ZERO      = 3'd1,
    STS_NO_FIT    = 3'd2,
    STS_NOT_FOUND = 3'd3,
    STS_DBL_FREE  = 3'd4,
    STS_FULL      = 3'd5
  } status_e;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] addr;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [ADDR_W-1:0] out_addr;
  } out_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [SIZE_W-1:0] size;
    logic              used;
  } seg_t;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WHOLE,
    ACT_SPLIT,
    ACT_FREE,
    ACT_INIT
  } act_e;

  typedef enum logic [2:0] {
    WS_NONE,
    WS_MOVE,
    WS_WHOLE,
    WS_HI,
    WS_LO,
    WS_MERGE,
    WS_INIT
  } wsel_e;

  typedef enum logic [3:0] {
    ST_BOOT,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_WHOLE,
    ST_SHIFT,
    ST_SPLIT_HI,
    ST_SPLIT_LO,
    ST_MERGE_FIX,
    ST_MERGE_MOVE,
    ST_INIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic  load;
    logic  eval;
    logic  latch_res;
    wsel_e wsel;
    logic  start_split;
    logic  start_merge;
    logic  cnt_init;
    logic  cnt_inc;
    logic  cnt_merge;
  } cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  eng_done;
    act_e  act;
  } sts_t;

endpackage

@@ rtl/bfpa_dp.sv @@
module bfpa_dp #(
  parameter int unsigned MaxSeg = bfpa_pkg::MAX_SEGMENTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bfpa_pkg::in_t  req_i,
  input  bfpa_pkg::cmd_t cmd_i,
  output bfpa_pkg::sts_t sts_o,
  output bfpa_pkg::out_t res_o
);
  import bfpa_pkg::*;

  localparam int unsigned AW = $clog2(MaxSeg);
  localparam int unsigned CW = AW + 1;
  localparam logic [SIZE_W:0]   HDR      = (SIZE_W+1)'(HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SZ  = SIZE_W'(POOL_BYTES - HEADER_BYTES);
  localparam logic [CW-1:0]     MAX_CNT  = CW'(MaxSeg);

  seg_t mem [MaxSeg];
  seg_t rdata_q;

  in_t           rq_q;
  logic [CW-1:0] count_q, ptr_q, lim_q, pos_q;
  logic          run_q, up_q, pend_q;
  logic [1:0]    off_q;

  // scan results
  logic          found_q, grab_q, nxt_v_q;
  logic [AW-1:0] best_idx_q, hit_idx_q;
  seg_t          best_q, hit_q, prev_q, nxt_q, last_q;
  out_t          res_q;

  logic          active, rd_go;
  logic          we;
  logic [AW-1:0] waddr;
  seg_t          wdata;

  assign active = up_q ? (ptr_q < lim_q) : (ptr_q > lim_q);
  assign rd_go  = run_q && active;

  // merge of a freed segment with its free neighbors
  logic            prev_free, next_free;
  logic [AW-1:0]   m_idx;
  logic [1:0]      merges;
  logic [SIZE_W:0] msize;
  seg_t            merged;

  always_comb begin
    prev_free = (hit_idx_q != '0) && !prev_q.used;
    next_free = nxt_v_q && !nxt_q.used;
    m_idx     = prev_free ? hit_idx_q - AW'(1) : hit_idx_q;
    merges    = {1'b0, prev_free} + {1'b0, next_free};
    msize     = {1'b0, hit_q.size};
    if (prev_free) msize = msize + {1'b0, prev_q.size} + HDR;
    if (next_free) msize = msize + {1'b0, nxt_q.size} + HDR;
    merged.start = next_free ? nxt_q.start : hit_q.start;
    merged.size  = msize[SIZE_W-1:0];
    merged.used  = 1'b0;
  end

  // decision
  logic [SIZE_W:0] sum_h;
  act_e            act;
  status_e         status;

  assign sum_h = {1'b0, rq_q.req_size} + HDR;

  always_comb begin
    act    = ACT_NONE;
    status = STS_OK;
    case (mode_e'(rq_q.mode))
      MODE_ALLOC: begin
        if (rq_q.req_size == '0) begin
          status = STS_ZERO;
        end else if (!found_q) begin
          status = STS_NO_FIT;
        end else if (sum_h >= {1'b0, best_q.size}) begin
          act = ACT_WHOLE;
        end else if (count_q >= MAX_CNT) begin
          status = STS_FULL;
        end else begin
          act = ACT_SPLIT;
        end
      end
      MODE_FREE: begin
        if (!found_q) begin
          status = STS_NOT_FOUND;
        end else if (!hit_q.used) begin
          status = STS_DBL_FREE;
        end else begin
          act = ACT_FREE;
        end
      end
      MODE_INIT: act = ACT_INIT;
      default:   act = ACT_NONE;
    endcase
  end

  // write port select
  logic [CW-1:0]   mv_dst;
  logic [SIZE_W:0] lo_start, lo_size;

  assign mv_dst   = up_q ? (pos_q - CW'(off_q)) : (pos_q + CW'(1));
  assign lo_start = {2'b00, best_q.start} + sum_h;
  assign lo_size  = {1'b0, best_q.size} - sum_h;

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    unique case (cmd_i.wsel)
      WS_NONE: ;
      WS_MOVE: begin
        we    = pend_q;
        waddr = mv_dst[AW-1:0];
        wdata = rdata_q;
      end
      WS_WHOLE: begin
        we    = 1'b1;
        waddr = best_idx_q;
        wdata = '{start: best_q.start, size: best_q.size, used: 1'b1};
      end
      WS_HI: begin
        we    = 1'b1;
        waddr = best_idx_q + AW'(1);
        wdata = '{start: best_q.start, size: rq_q.req_size, used: 1'b1};
      end
      WS_LO: begin
        we    = 1'b1;
        waddr = best_idx_q;
        wdata = '{start: lo_start[ADDR_W-1:0], size: lo_size[SIZE_W-1:0], used: 1'b0};
      end
      WS_MERGE: begin
        we    = 1'b1;
        waddr = m_idx;
        wdata = merged;
      end
      WS_INIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{start: '0, size: INIT_SZ, used: 1'b0};
      end
      default: ;
    endcase
  end

  // segment table, one read and one write port
  always_ff @(posedge clk_i) begin
    if (rd_go) rdata_q <= mem[ptr_q[AW-1:0]];
    if (we)    mem[waddr] <= wdata;
  end

  // read engine and segment count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      pend_q  <= 1'b0;
      count_q <= CW'(1);
    end else begin
      pend_q <= rd_go;
      if (cmd_i.load) begin
        run_q <= (mode_e'(req_i.mode) == MODE_ALLOC) || (mode_e'(req_i.mode) == MODE_FREE);
      end else if (cmd_i.start_split || cmd_i.start_merge) begin
        run_q <= 1'b1;
      end else if (run_q && !active) begin
        run_q <= 1'b0;
      end
      if (cmd_i.cnt_init) begin
        count_q <= CW'(1);
      end else if (cmd_i.cnt_inc) begin
        count_q <= count_q + CW'(1);
      end else if (cmd_i.cnt_merge) begin
        count_q <= count_q - CW'(merges);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= ptr_q;
    if (cmd_i.load) begin
      up_q  <= 1'b1;
      ptr_q <= '0;
      lim_q <= count_q;
      off_q <= '0;
    end else if (cmd_i.start_split) begin
      // ripple entries up from the top down to just past the chosen one
      up_q  <= 1'b0;
      ptr_q <= count_q - CW'(1);
      lim_q <= {1'b0, best_idx_q};
    end else if (cmd_i.start_merge) begin
      up_q  <= 1'b1;
      ptr_q <= {1'b0, m_idx} + CW'(1) + CW'(merges);
      lim_q <= count_q;
      off_q <= merges;
    end else if (rd_go) begin
      ptr_q <= up_q ? ptr_q + CW'(1) : ptr_q - CW'(1);
    end
  end

  // scan evaluation
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rq_q    <= req_i;
      found_q <= 1'b0;
      grab_q  <= 1'b0;
      nxt_v_q <= 1'b0;
    end else if (cmd_i.eval && pend_q) begin
      last_q <= rdata_q;
      if (mode_e'(rq_q.mode) == MODE_ALLOC) begin
        if (!rdata_q.used && rq_q.req_size <= rdata_q.size &&
            (!found_q || rdata_q.size < best_q.size)) begin
          found_q    <= 1'b1;
          best_q     <= rdata_q;
          best_idx_q <= pos_q[AW-1:0];
        end
      end else begin
        if (!found_q && rdata_q.start == rq_q.addr) begin
          found_q   <= 1'b1;
          hit_q     <= rdata_q;
          hit_idx_q <= pos_q[AW-1:0];
          prev_q    <= last_q;
          grab_q    <= 1'b1;
        end else if (grab_q) begin
          nxt_q   <= rdata_q;
          nxt_v_q <= 1'b1;
          grab_q  <= 1'b0;
        end
      end
    end
    if (cmd_i.latch_res) begin
      res_q.status   <= status;
      res_q.out_addr <= (act == ACT_WHOLE || act == ACT_SPLIT) ? best_q.start : '0;
    end
  end

  assign sts_o.mode     = mode_e'(rq_q.mode);
  assign sts_o.eng_done = !run_q && !pend_q;
  assign sts_o.act      = act;
  assign res_o          = res_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= MAX_CNT)
    else $error("segment count out of range");

  a_pend_follows_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> $past(run_q))
    else $error("read data without an issued read");

endmodule

@@ rtl/bfpa_ctrl.sv @@
module bfpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  input  bfpa_pkg::in_t  in_data_i,
  input  bfpa_pkg::sts_t sts_i,
  output logic           in_ready_o,
  output logic           out_load_o,
  output bfpa_pkg::cmd_t cmd_o
);
  import bfpa_pkg::*;

  state_e state_q, state_d;
  logic   scans;

  assign scans = (mode_e'(in_data_i.mode) == MODE_ALLOC) ||
                 (mode_e'(in_data_i.mode) == MODE_FREE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_BOOT:       state_d = ST_IDLE;
      ST_IDLE:       if (in_valid_i) state_d = scans ? ST_SCAN : ST_DECIDE;
      ST_SCAN:       if (sts_i.eng_done) state_d = ST_DECIDE;
      ST_DECIDE: begin
        unique case (sts_i.act)
          ACT_WHOLE: state_d = ST_WHOLE;
          ACT_SPLIT: state_d = ST_SHIFT;
          ACT_FREE:  state_d = ST_MERGE_FIX;
          ACT_INIT:  state_d = ST_INIT;
          default:   state_d = ST_DONE;
        endcase
      end
      ST_WHOLE:      state_d = ST_DONE;
      ST_SHIFT:      if (sts_i.eng_done) state_d = ST_SPLIT_HI;
      ST_SPLIT_HI:   state_d = ST_SPLIT_LO;
      ST_SPLIT_LO:   state_d = ST_DONE;
      ST_MERGE_FIX:  state_d = ST_MERGE_MOVE;
      ST_MERGE_MOVE: if (sts_i.eng_done) state_d = ST_DONE;
      ST_INIT:       state_d = ST_DONE;
      ST_DONE:       if (out_free_i) state_d = ST_IDLE;
      default:       state_d = ST_BOOT;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wsel = WS_NONE;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    unique case (state_q)
      ST_BOOT: begin
        cmd_o.wsel     = WS_INIT;
        cmd_o.cnt_init = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN:   cmd_o.eval = 1'b1;
      ST_DECIDE: begin
        cmd_o.latch_res   = 1'b1;
        cmd_o.start_split = (sts_i.act == ACT_SPLIT);
      end
      ST_WHOLE:    cmd_o.wsel = WS_WHOLE;
      ST_SHIFT:    cmd_o.wsel = WS_MOVE;
      ST_SPLIT_HI: cmd_o.wsel = WS_HI;
      ST_SPLIT_LO: begin
        cmd_o.wsel    = WS_LO;
        cmd_o.cnt_inc = 1'b1;
      end
      ST_MERGE_FIX: begin
        cmd_o.wsel        = WS_MERGE;
        cmd_o.start_merge = 1'b1;
        cmd_o.cnt_merge   = 1'b1;
      end
      ST_MERGE_MOVE: cmd_o.wsel = WS_MOVE;
      ST_INIT: begin
        cmd_o.wsel     = WS_INIT;
        cmd_o.cnt_init = 1'b1;
      end
      ST_DONE: out_load_o = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_BOOT;
    end else begin
      state_q <= state_d;
    end
  end

  a_scan_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN |=> state_q == ST_SCAN || state_q == ST_DECIDE)
    else $error("scan left to an unexpected state");

endmodule

@@ rtl/best_fit_pool_allocator_unit.sv @@
// Best-fit allocator over a byte pool, one request transaction in, one result out.
// Input channel in_valid_i/in_ready_o carries mode, req_size and addr; the output
// channel out_valid_o/out_ready_i carries status and out_addr.
// Requests are handled one at a time. A transaction walks the segment table
// through the single read port of the table memory, one entry per cycle:
//   allocate/free scan: one read per segment in the table
//   split insert: one move per entry above the chosen one, then the high and low writes
//   free with merge: the merged entry is written, then one move per entry above it
//   reinitialize and no-op: no table walk; reinitialize rewrites the initial segment
// After reset the block writes the initial free segment and raises in_ready_o
// in the cycle after; the table starts as one free segment of
// POOL_BYTES - HEADER_BYTES.
// Results wait in an output register. A new request is accepted while a result
// is still pending; the block only holds its next result when the receiver
// stalls.
module best_fit_pool_allocator_unit #(
  parameter int unsigned MaxSeg = bfpa_pkg::MAX_SEGMENTS
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  bfpa_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output bfpa_pkg::out_t out_data_o
);
  import bfpa_pkg::*;

  cmd_t cmd;
  sts_t sts;
  out_t res;
  logic out_load, out_free;
  logic out_valid_q;
  out_t out_q;

  // output slot is free when empty or being drained this cycle
  assign out_free = !out_valid_q || out_ready_i;

  bfpa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .in_data_i  (in_data_i),
    .sts_i      (sts),
    .in_ready_o (in_ready_o),
    .out_load_o (out_load),
    .cmd_o      (cmd)
  );

  bfpa_dp #(.MaxSeg(MaxSeg)) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_data_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

endmodule
